>>> hw/rtl/qlsf_pkg.sv
package qlsf_pkg;

  localparam int MAX_SAMPLES_DEF = 256;
  localparam int CNT_W           = 9;
  localparam int QDEPTH          = 2;
  localparam int WIDE_W          = 112;
  localparam int OPB_W           = 54;
  localparam int DVD_W           = WIDE_W + 32;
  localparam int QUO_W           = 66;
  localparam int NSTEPS          = 24;
  localparam int STEP_W          = 5;
  localparam int COEF_W          = 64;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic [COEF_W-1:0] Q_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] Q_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // Running sums of one sample set.
  typedef struct packed {
    logic [CNT_W-1:0]   cnt;
    logic signed [20:0] sx;
    logic signed [24:0] sy;
    logic signed [31:0] sx2;
    logic signed [42:0] sx3;
    logic signed [53:0] sx4;
    logic signed [35:0] sxy;
    logic signed [46:0] sx2y;
  } sums_t;

  // Operands of the solver: matrix entries, right-hand side, cofactors, determinants.
  typedef enum logic [4:0] {
    OP_M00, OP_M01, OP_M02, OP_M12, OP_M22, OP_R0, OP_R1, OP_R2,
    OP_C00, OP_C01, OP_C02, OP_C11, OP_C12, OP_C22, OP_DD, OP_N0, OP_N1, OP_N2
  } opnd_t;

  typedef struct packed {
    opnd_t a_sel;
    opnd_t b_sel;
    logic  neg;
    logic  first;
    logic  last;
    opnd_t dst;
  } step_t;

  function automatic step_t mk(input opnd_t a, input opnd_t b, input logic neg,
                               input logic first, input logic last, input opnd_t dst);
    step_t s;
    s.a_sel = a;
    s.b_sel = b;
    s.neg   = neg;
    s.first = first;
    s.last  = last;
    s.dst   = dst;
    return s;
  endfunction

  // Multiply-accumulate program: six cofactors, then the determinant and
  // the three Cramer numerators as dot products with cofactor columns.
  function automatic step_t step_of(input logic [STEP_W-1:0] idx);
    step_t s;
    unique case (idx)
      5'd0:    s = mk(OP_M02, OP_M22, 1'b0, 1'b1, 1'b0, OP_C00);
      5'd1:    s = mk(OP_M12, OP_M12, 1'b1, 1'b0, 1'b1, OP_C00);
      5'd2:    s = mk(OP_M12, OP_M02, 1'b0, 1'b1, 1'b0, OP_C01);
      5'd3:    s = mk(OP_M01, OP_M22, 1'b1, 1'b0, 1'b1, OP_C01);
      5'd4:    s = mk(OP_M01, OP_M12, 1'b0, 1'b1, 1'b0, OP_C02);
      5'd5:    s = mk(OP_M02, OP_M02, 1'b1, 1'b0, 1'b1, OP_C02);
      5'd6:    s = mk(OP_M00, OP_M22, 1'b0, 1'b1, 1'b0, OP_C11);
      5'd7:    s = mk(OP_M02, OP_M02, 1'b1, 1'b0, 1'b1, OP_C11);
      5'd8:    s = mk(OP_M01, OP_M02, 1'b0, 1'b1, 1'b0, OP_C12);
      5'd9:    s = mk(OP_M00, OP_M12, 1'b1, 1'b0, 1'b1, OP_C12);
      5'd10:   s = mk(OP_M00, OP_M02, 1'b0, 1'b1, 1'b0, OP_C22);
      5'd11:   s = mk(OP_M01, OP_M01, 1'b1, 1'b0, 1'b1, OP_C22);
      5'd12:   s = mk(OP_C00, OP_M00, 1'b0, 1'b1, 1'b0, OP_DD);
      5'd13:   s = mk(OP_C01, OP_M01, 1'b0, 1'b0, 1'b0, OP_DD);
      5'd14:   s = mk(OP_C02, OP_M02, 1'b0, 1'b0, 1'b1, OP_DD);
      5'd15:   s = mk(OP_C00, OP_R0,  1'b0, 1'b1, 1'b0, OP_N0);
      5'd16:   s = mk(OP_C01, OP_R1,  1'b0, 1'b0, 1'b0, OP_N0);
      5'd17:   s = mk(OP_C02, OP_R2,  1'b0, 1'b0, 1'b1, OP_N0);
      5'd18:   s = mk(OP_C01, OP_R0,  1'b0, 1'b1, 1'b0, OP_N1);
      5'd19:   s = mk(OP_C11, OP_R1,  1'b0, 1'b0, 1'b0, OP_N1);
      5'd20:   s = mk(OP_C12, OP_R2,  1'b0, 1'b0, 1'b1, OP_N1);
      5'd21:   s = mk(OP_C02, OP_R0,  1'b0, 1'b1, 1'b0, OP_N2);
      5'd22:   s = mk(OP_C12, OP_R1,  1'b0, 1'b0, 1'b0, OP_N2);
      5'd23:   s = mk(OP_C22, OP_R2,  1'b0, 1'b0, 1'b1, OP_N2);
      default: s = mk(OP_M00, OP_M00, 1'b0, 1'b1, 1'b1, OP_DD);
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/qlsf_front.sv
module qlsf_front #(
  parameter int MAX_SAMPLES = qlsf_pkg::MAX_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [11:0]  in_x_value,
  input  logic signed [15:0]  in_y_value,
  input  logic                in_last,
  input  logic                push,
  output logic                full,
  input  logic                q_full,
  output logic                q_push,
  output qlsf_pkg::sums_t     q_data
);

  logic               s1_v_r, s2_v_r;
  logic signed [11:0] x1_r, x2s_r;
  logic signed [15:0] y1_r, y2s_r;
  logic               last1_r, last2_r;
  logic signed [23:0] sq1_r, sq2_r;
  logic signed [35:0] cube_r;
  logic signed [47:0] four_r;
  logic signed [27:0] xy_r;
  logic signed [39:0] sqy_r;
  qlsf_pkg::sums_t    sums_r, sums_add, sums_nxt;
  logic               adv, acc, take;

  // The pipe stops only when a finished set cannot enter the queue.
  assign adv  = !(s2_v_r && last2_r && q_full);
  assign full = !adv;
  assign acc  = s2_v_r && adv;
  assign take = sums_r.cnt < qlsf_pkg::CNT_W'(MAX_SAMPLES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= push;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r    <= in_x_value;
      y1_r    <= in_y_value;
      last1_r <= in_last;
      sq1_r   <= 24'(in_x_value * in_x_value);
      x2s_r   <= x1_r;
      y2s_r   <= y1_r;
      last2_r <= last1_r;
      sq2_r   <= sq1_r;
      cube_r  <= 36'(sq1_r * x1_r);
      four_r  <= 48'(sq1_r * sq1_r);
      xy_r    <= 28'(x1_r * y1_r);
      sqy_r   <= 40'(sq1_r * y1_r);
    end
  end

  always_comb begin
    sums_add = sums_r;
    if (take) begin
      sums_add.cnt  = sums_r.cnt + 1'b1;
      sums_add.sx   = sums_r.sx + 21'(x2s_r);
      sums_add.sy   = sums_r.sy + 25'(y2s_r);
      sums_add.sx2  = sums_r.sx2 + 32'(sq2_r);
      sums_add.sx3  = sums_r.sx3 + 43'(cube_r);
      sums_add.sx4  = sums_r.sx4 + 54'(four_r);
      sums_add.sxy  = sums_r.sxy + 36'(xy_r);
      sums_add.sx2y = sums_r.sx2y + 47'(sqy_r);
    end
    sums_nxt = sums_r;
    if (acc) sums_nxt = last2_r ? '0 : sums_add;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sums_r <= '0;
    else        sums_r <= sums_nxt;
  end

  assign q_push = acc && last2_r;
  assign q_data = sums_add;

  a_clear_after_set: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> sums_r == '0) else $error("sums not cleared after a set");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("set pushed into a full queue");
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    sums_r.cnt <= qlsf_pkg::CNT_W'(MAX_SAMPLES)) else $error("sample count beyond limit");

endmodule

>>> hw/rtl/qlsf_queue.sv
module qlsf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_push,
  input  qlsf_pkg::sums_t q_wdata,
  output logic            q_full,
  input  logic            q_pop,
  output logic            q_empty,
  output qlsf_pkg::sums_t q_rdata
);

  localparam int PW = (qlsf_pkg::QDEPTH > 1) ? $clog2(qlsf_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(qlsf_pkg::QDEPTH + 1);

  qlsf_pkg::sums_t mem_r [qlsf_pkg::QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign q_full  = cnt_r == CW'(qlsf_pkg::QDEPTH);
  assign q_empty = cnt_r == '0;
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_rdata = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= q_wdata;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(qlsf_pkg::QDEPTH)) else $error("queue fill beyond depth");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("push lost");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> cnt_r == $past(cnt_r) - 1'b1) else $error("pop lost");

endmodule

>>> hw/rtl/qlsf_solve.sv
module qlsf_solve (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  qlsf_pkg::sums_t     q_rdata,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic signed [63:0]  out_coef_const,
  output logic signed [63:0]  out_coef_linear,
  output logic signed [63:0]  out_coef_square,
  output logic [1:0]          out_fit_status
);

  localparam int W  = qlsf_pkg::WIDE_W;
  localparam int BW = qlsf_pkg::OPB_W;
  localparam int DW = qlsf_pkg::DVD_W;
  localparam int QW = qlsf_pkg::QUO_W;
  localparam int CF = qlsf_pkg::COEF_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MINIT  = 8'b0000_0010,
    S_MRUN   = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_DINIT  = 8'b0001_0000,
    S_DRUN   = 8'b0010_0000,
    S_DROUND = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t                       state_r, state_nxt;
  qlsf_pkg::sums_t              m_r;
  logic signed [W-1:0]          c00_r, c01_r, c02_r, c11_r, c12_r, c22_r;
  logic signed [W-1:0]          dd_r, n0_r, n1_r, n2_r;
  logic [W-1:0]                 acc_r, ash_r, acc_add;
  logic [BW-1:0]                bmag_r;
  logic                         bsgn_r;
  logic [qlsf_pkg::STEP_W-1:0]  step_r;
  qlsf_pkg::step_t              st;
  logic signed [W-1:0]          opa;
  logic signed [BW-1:0]         opb;
  logic [1:0]                   k_r;
  logic [DW-1:0]                dvd_r;
  logic [W-1:0]                 den_r, rem_r, rem_nxt;
  logic [QW-1:0]                quo_r;
  logic                         ovf_r, qneg_r, sat_r, sing_r;
  logic [7:0]                   bitcnt_r;
  logic signed [W-1:0]          nsel;
  logic [W:0]                   r_sh, diff;
  logic                         ge, rup, rsat;
  logic [QW:0]                  qsum;
  logic [CF-1:0]                coefval;
  logic [CF-1:0]                res_r [3];
  logic                         out_v_r, ld_out, mdone;

  assign st    = qlsf_pkg::step_of(step_r);
  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign empty = !out_v_r;
  assign ld_out = (state_r == S_DONE) && (!out_v_r || pop);
  assign mdone = bmag_r == '0;

  always_comb begin
    case (st.a_sel)
      qlsf_pkg::OP_M00: opa = W'(m_r.cnt);
      qlsf_pkg::OP_M01: opa = W'(m_r.sx);
      qlsf_pkg::OP_M02: opa = W'(m_r.sx2);
      qlsf_pkg::OP_M12: opa = W'(m_r.sx3);
      qlsf_pkg::OP_M22: opa = W'(m_r.sx4);
      qlsf_pkg::OP_C00: opa = c00_r;
      qlsf_pkg::OP_C01: opa = c01_r;
      qlsf_pkg::OP_C02: opa = c02_r;
      qlsf_pkg::OP_C11: opa = c11_r;
      qlsf_pkg::OP_C12: opa = c12_r;
      qlsf_pkg::OP_C22: opa = c22_r;
      default:          opa = '0;
    endcase
    case (st.b_sel)
      qlsf_pkg::OP_M00: opb = BW'(m_r.cnt);
      qlsf_pkg::OP_M01: opb = BW'(m_r.sx);
      qlsf_pkg::OP_M02: opb = BW'(m_r.sx2);
      qlsf_pkg::OP_M12: opb = BW'(m_r.sx3);
      qlsf_pkg::OP_M22: opb = m_r.sx4;
      qlsf_pkg::OP_R0:  opb = BW'(m_r.sy);
      qlsf_pkg::OP_R1:  opb = BW'(m_r.sxy);
      qlsf_pkg::OP_R2:  opb = BW'(m_r.sx2y);
      default:          opb = '0;
    endcase
    case (k_r)
      2'd1:    nsel = n1_r;
      2'd2:    nsel = n2_r;
      default: nsel = n0_r;
    endcase
  end

  // One shift-add of the serial multiplier; the sign rides on the addend.
  assign acc_add = acc_r + (ash_r ^ {W{bsgn_r}}) + W'(bsgn_r);

  // One restoring division step, then round half away from zero.
  assign r_sh    = {rem_r, dvd_r[DW-1]};
  assign diff    = r_sh - {1'b0, den_r};
  assign ge      = r_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? diff[W-1:0] : r_sh[W-1:0];
  assign rup     = {rem_r, 1'b0} >= {1'b0, den_r};
  assign qsum    = {1'b0, quo_r} + (QW+1)'(rup);
  assign rsat    = ovf_r || (qsum[QW:CF] != '0) ||
                   (qneg_r ? (qsum[CF-1:0] > qlsf_pkg::Q_MIN) : qsum[CF-1]);
  assign coefval = rsat ? (qneg_r ? qlsf_pkg::Q_MIN : qlsf_pkg::Q_MAX)
                        : (qneg_r ? (~qsum[CF-1:0] + 1'b1) : qsum[CF-1:0]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (!q_empty) state_nxt = S_MINIT;
      S_MINIT:  state_nxt = S_MRUN;
      S_MRUN:   if (mdone) state_nxt = (step_r == qlsf_pkg::STEP_W'(qlsf_pkg::NSTEPS - 1))
                                       ? S_CHECK : S_MINIT;
      S_CHECK:  state_nxt = (dd_r == '0) ? S_DONE : S_DINIT;
      S_DINIT:  state_nxt = S_DRUN;
      S_DRUN:   if (bitcnt_r == 8'd1) state_nxt = S_DROUND;
      S_DROUND: state_nxt = (k_r == 2'd2) ? S_DONE : S_DINIT;
      S_DONE:   if (ld_out) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld_out)            out_v_r <= 1'b1;
      else if (pop)          out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        m_r    <= q_rdata;
        step_r <= '0;
      end
      S_MINIT: begin
        ash_r  <= opa;
        bmag_r <= opb[BW-1] ? BW'(-opb) : opb;
        bsgn_r <= opb[BW-1] ^ st.neg;
        if (st.first) acc_r <= '0;
      end
      S_MRUN: begin
        if (mdone) begin
          step_r <= step_r + 1'b1;
          if (st.last) begin
            case (st.dst)
              qlsf_pkg::OP_C00: c00_r <= acc_r;
              qlsf_pkg::OP_C01: c01_r <= acc_r;
              qlsf_pkg::OP_C02: c02_r <= acc_r;
              qlsf_pkg::OP_C11: c11_r <= acc_r;
              qlsf_pkg::OP_C12: c12_r <= acc_r;
              qlsf_pkg::OP_C22: c22_r <= acc_r;
              qlsf_pkg::OP_DD:  dd_r  <= acc_r;
              qlsf_pkg::OP_N0:  n0_r  <= acc_r;
              qlsf_pkg::OP_N1:  n1_r  <= acc_r;
              qlsf_pkg::OP_N2:  n2_r  <= acc_r;
              default: ;
            endcase
          end
        end else begin
          if (bmag_r[0]) acc_r <= acc_add;
          ash_r  <= ash_r << 1;
          bmag_r <= bmag_r >> 1;
        end
      end
      S_CHECK: begin
        sing_r <= dd_r == '0;
        sat_r  <= 1'b0;
        k_r    <= '0;
        res_r[0] <= '0;
        res_r[1] <= '0;
        res_r[2] <= '0;
      end
      S_DINIT: begin
        qneg_r   <= nsel[W-1] ^ dd_r[W-1];
        dvd_r    <= {(nsel[W-1] ? W'(-nsel) : nsel), 32'd0};
        den_r    <= dd_r[W-1] ? W'(-dd_r) : dd_r;
        rem_r    <= '0;
        quo_r    <= '0;
        ovf_r    <= 1'b0;
        bitcnt_r <= 8'(DW);
      end
      S_DRUN: begin
        rem_r    <= rem_nxt;
        dvd_r    <= dvd_r << 1;
        quo_r    <= {quo_r[QW-2:0], ge};
        ovf_r    <= ovf_r | quo_r[QW-1];
        bitcnt_r <= bitcnt_r - 1'b1;
      end
      S_DROUND: begin
        res_r[k_r] <= coefval;
        sat_r      <= sat_r | rsat;
        k_r        <= k_r + 1'b1;
      end
      S_DONE: begin
        if (ld_out) begin
          out_coef_const  <= res_r[0];
          out_coef_linear <= res_r[1];
          out_coef_square <= res_r[2];
          out_fit_status  <= sing_r ? qlsf_pkg::ST_SINGULAR
                           : (sat_r ? qlsf_pkg::ST_SAT : qlsf_pkg::ST_OK);
        end
      end
      default: ;
    endcase
  end

  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_MINIT) else $error("set taken without starting the solve");
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_fit_status == qlsf_pkg::ST_SINGULAR) |->
      (out_coef_const == '0 && out_coef_linear == '0 && out_coef_square == '0))
    else $error("singular result with nonzero coefficients");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_fit_status != 2'd3) else $error("undefined status code");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !pop) |=> $stable(out_coef_const) && out_v_r)
    else $error("waiting result changed");

endmodule

>>> hw/rtl/quadratic_least_squares_fit.sv
// Quadratic least-squares fit. Samples (x, y) enter one per clock through
// the push/full queue interface and run through a three-beat pipeline that
// forms x^2, x^3, x^4, xy and x^2y and adds them into exact integer sums.
// Once MAX_SAMPLES samples are held, further samples are dropped from the
// sums; a sample flagged last still closes the set. A closed set is handed
// to a two-entry queue and the sums clear at once, so the next set streams
// in without a gap. The solver behind the queue takes one set at a time:
// 24 multiply-accumulate steps on a bit-serial multiplier, which walks the
// significant bits of the sum operand, build the cofactors, the determinant
// and the three Cramer numerators, and then a restoring divider forms each
// of the three Q31.32 coefficients in turn. A singular set skips the division
// and finishes after the multiply steps alone. Input is held off (full high)
// only while the queue is full and the pipeline holds another last sample.
// A zero determinant gives status singular with zero coefficients; a
// coefficient out of range saturates and gives status saturated. The result
// waits on the out_ ports while empty is low.
module quadratic_least_squares_fit #(
  parameter int MAX_SAMPLES = qlsf_pkg::MAX_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [11:0]  in_x_value,
  input  logic signed [15:0]  in_y_value,
  input  logic                in_last,
  input  logic                push,
  output logic                full,
  output logic signed [63:0]  out_coef_const,
  output logic signed [63:0]  out_coef_linear,
  output logic signed [63:0]  out_coef_square,
  output logic [1:0]          out_fit_status,
  output logic                empty,
  input  logic                pop
);

  qlsf_pkg::sums_t set_wdata, set_rdata;
  logic            set_push, set_full, set_pop, set_empty;

  // Front: sample pipeline and running sums.
  qlsf_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_x_value (in_x_value),
    .in_y_value (in_y_value),
    .in_last    (in_last),
    .push       (push),
    .full       (full),
    .q_full     (set_full),
    .q_push     (set_push),
    .q_data     (set_wdata)
  );

  // Queue of closed sets between the front and the solver.
  qlsf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (set_push),
    .q_wdata (set_wdata),
    .q_full  (set_full),
    .q_pop   (set_pop),
    .q_empty (set_empty),
    .q_rdata (set_rdata)
  );

  // Back: normal equations, elimination by cofactors, division, output beat.
  qlsf_solve u_solve (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (set_empty),
    .q_rdata         (set_rdata),
    .q_pop           (set_pop),
    .empty           (empty),
    .pop             (pop),
    .out_coef_const  (out_coef_const),
    .out_coef_linear (out_coef_linear),
    .out_coef_square (out_coef_square),
    .out_fit_status  (out_fit_status)
  );

endmodule

>>> bench/fit_checker.sv
`timescale 1ns / 1ps

module fit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [11:0] in_x_value,
  input  logic signed [15:0] in_y_value,
  input  logic               in_last,
  input  logic               push,
  input  logic               full,
  input  logic signed [63:0] out_coef_const,
  input  logic signed [63:0] out_coef_linear,
  input  logic signed [63:0] out_coef_square,
  input  logic [1:0]         out_fit_status,
  input  logic               empty,
  input  logic               pop,
  output int                 fail_count,
  output int                 pending_fits
);

  typedef struct {
    logic signed [63:0] c0;
    logic signed [63:0] c1;
    logic signed [63:0] c2;
    logic [1:0]         status;
  } fit_t;

  fit_t fit_q[$];
  int unsigned n_acc;
  longint s_x, s_y, s_x2, s_x3, s_x4, s_xy, s_x2y;

  assign pending_fits = fit_q.size();

  function automatic logic signed [199:0] det_of(
      input logic signed [199:0] a, b, c, d, e, f, g, h, i);
    return a * (e * i - f * h) - b * (d * i - f * g) + c * (d * h - e * g);
  endfunction

  // Rounded (ties away from zero), saturated Q31.32 of num / den.
  function automatic logic signed [63:0] to_q32(input logic signed [199:0] num,
                                                input logic signed [199:0] den,
                                                inout logic sat);
    logic neg;
    logic [199:0] n, d, q, r;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    n = n << 32;
    q = n / d;
    r = n % d;
    if ((r << 1) >= d) q = q + 1;
    if (!neg && q > 200'h7FFFFFFFFFFFFFFF) begin
      sat = 1'b1;
      return qlsf_pkg::Q_MAX;
    end
    if (neg && q > 200'h8000000000000000) begin
      sat = 1'b1;
      return qlsf_pkg::Q_MIN;
    end
    return neg ? -q[63:0] : q[63:0];
  endfunction

  task automatic add_sample(input longint xv, input longint yv, input logic closes);
    fit_t f;
    logic signed [199:0] dd, n0, n1, n2;
    logic sat;
    if (n_acc < qlsf_pkg::MAX_SAMPLES_DEF) begin
      n_acc++;
      s_x += xv; s_y += yv; s_x2 += xv * xv; s_x3 += xv * xv * xv;
      s_x4 += xv * xv * xv * xv; s_xy += xv * yv; s_x2y += xv * xv * yv;
    end
    if (!closes) return;
    sat = 1'b0;
    dd = det_of(n_acc, s_x, s_x2, s_x, s_x2, s_x3, s_x2, s_x3, s_x4);
    if (dd == 0) begin
      f.c0 = '0; f.c1 = '0; f.c2 = '0; f.status = qlsf_pkg::ST_SINGULAR;
    end else begin
      n0 = det_of(s_y, s_x, s_x2, s_xy, s_x2, s_x3, s_x2y, s_x3, s_x4);
      n1 = det_of(n_acc, s_y, s_x2, s_x, s_xy, s_x3, s_x2, s_x2y, s_x4);
      n2 = det_of(n_acc, s_x, s_y, s_x, s_x2, s_xy, s_x2, s_x3, s_x2y);
      f.c0 = to_q32(n0, dd, sat);
      f.c1 = to_q32(n1, dd, sat);
      f.c2 = to_q32(n2, dd, sat);
      f.status = sat ? qlsf_pkg::ST_SAT : qlsf_pkg::ST_OK;
    end
    fit_q.push_back(f);
    n_acc = 0;
    s_x = 0; s_y = 0; s_x2 = 0; s_x3 = 0; s_x4 = 0; s_xy = 0; s_x2y = 0;
  endtask

  initial begin
    fail_count = 0;
    n_acc = 0;
    s_x = 0; s_y = 0; s_x2 = 0; s_x3 = 0; s_x4 = 0; s_xy = 0; s_x2y = 0;
  end

  always @(posedge clk) begin
    fit_t e;
    if (rst_n && push && !full)
      add_sample(longint'(in_x_value), longint'(in_y_value), in_last);
    if (rst_n && pop && !empty) begin
      if (fit_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected fit beat at %0t", $realtime);
      end else begin
        e = fit_q.pop_front();
        if (e.c0 !== out_coef_const || e.c1 !== out_coef_linear ||
            e.c2 !== out_coef_square || e.status !== out_fit_status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("fit mismatch: exp %h %h %h st %0d, got %h %h %h st %0d",
                     e.c0, e.c1, e.c2, e.status, out_coef_const,
                     out_coef_linear, out_coef_square, out_fit_status);
        end
      end
    end
  end
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  logic clk, rst_n;
  logic signed [11:0] in_x_value;
  logic signed [15:0] in_y_value;
  logic in_last, push, full, empty, pop;
  logic signed [63:0] out_coef_const, out_coef_linear, out_coef_square;
  logic [1:0] out_fit_status;
  int fail_count, pending_fits;
  // Idling is dropped once the run reaches its final stretch.
  bit calm;
  longint cycle_count;

  quadratic_least_squares_fit u_top (.*);
  fit_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: stops the run and reports failure if it never finishes; up to two sets can queue.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 3000000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // The result side pops in random bursts, with random gaps while calm is clear.
  initial begin
    int gap;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3);
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
    end
  end

  // Send one sample beat and wait for it to be taken.
  task automatic send_beat(input logic signed [11:0] xv, input logic signed [15:0] yv,
                           input logic closes);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    in_x_value = xv;
    in_y_value = yv;
    in_last = closes;
    push = 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // One sample set: random content, or points on a true parabola so that a
  // nonsingular fit returns exact, nonsaturated coefficients.
  task automatic send_set(input int n, input bit on_curve);
    int a0, a1, a2, xv, yv;
    a0 = $urandom_range(0, 2000) - 1000;
    a1 = $urandom_range(0, 20) - 10;
    a2 = $urandom_range(0, 2) - 1;
    for (int k = 0; k < n; k++) begin
      if (on_curve) begin
        xv = $urandom_range(0, 200) - 100;
        yv = a0 + a1 * xv + a2 * xv * xv;
      end else begin
        xv = $urandom_range(0, 4095) - 2048;
        yv = $urandom_range(0, 65535) - 32768;
      end
      send_beat(12'(xv), 16'(yv), k == n - 1);
    end
  endtask

  initial begin
    int sent, n;
    calm = 1'b0;
    push = 1'b0;
    in_x_value = '0;
    in_y_value = '0;
    in_last = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A lone last beat: one sample, so the system is singular.
    send_beat(0, 0, 1'b1);
    // Two distinct x values only: still singular.
    send_beat(-2048, 32767, 1'b0);
    send_beat(2047, -32768, 1'b1);
    // Extremes of x and y on three points; large coefficients.
    send_beat(-2048, -32768, 1'b0);
    send_beat(2047, 32767, 1'b0);
    send_beat(0, -32768, 1'b1);
    // A steep curve through nearly equal x values; large but unsaturated coefficients.
    send_beat(0, -32768, 1'b0);
    send_beat(1, 32767, 1'b0);
    send_beat(2, -32768, 1'b1);
    // A well-behaved exact parabola.
    send_set(5, 1'b1);

    // Let every fit drain before going on.
    push = 1'b0;
    wait (pending_fits == 0);
    @(negedge clk);

    // Overflow: more than the sample cap in one set; the last beat is dropped
    // from the sums yet still closes the set.
    send_set(qlsf_pkg::MAX_SAMPLES_DEF + 4, 1'b0);
    send_set(qlsf_pkg::MAX_SAMPLES_DEF, 1'b1);
    sent = 20 + 2 * qlsf_pkg::MAX_SAMPLES_DEF;

    while (sent < 1650) begin
      if (sent > 1400) calm = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 12);
      send_set(n, $urandom_range(0, 2) != 0);
      sent += n;
    end
    push = 1'b0;

    wait (pending_fits == 0);
    repeat (2000) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
